// File: design/ptc_pkg.sv
// Shared package of the placement table checker.
// Holds the payload structs, the status codes, register indexes and the
// command and status structs that join the controller and the datapath.
package ptc_pkg;

  localparam int MAX_NODES_DEF   = 1024;
  localparam int MAX_WORKERS_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int FIELD_W    = 16;
  localparam int COUNT_W    = 11;
  localparam int GRID_W     = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAST_LENGTH     = 2'd2;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_EMPTY        = 4'd1,
    ST_MISMATCH     = 4'd2,
    ST_BAD_GRID     = 4'd3,
    ST_BAD_SEQ      = 4'd4,
    ST_WORKER_RANGE = 4'd5,
    ST_SLOT_RANGE   = 4'd6,
    ST_SLOT_REUSED  = 4'd7,
    ST_OVERFLOW     = 4'd8
  } ptc_status_t;

  typedef struct packed {
    logic                      has_worker;
    logic signed [FIELD_W-1:0] worker_id;
    logic                      has_slot;
    logic signed [FIELD_W-1:0] slot_id;
    logic                      last;
  } ptc_in_t;

  typedef struct packed {
    ptc_status_t               status;
    logic [COUNT_W-1:0]        node_index;
    logic signed [FIELD_W-1:0] bad_worker;
    logic signed [FIELD_W-1:0] bad_slot;
    logic [COUNT_W-1:0]        queue_length;
    logic [COUNT_W-1:0]        worker_entries;
    logic [COUNT_W-1:0]        slot_entries;
  } ptc_out_t;

  typedef struct packed {
    logic        accept;
    logic        idx_clr;
    logic        idx_inc;
    logic        acc_clr;
    logic        q_by_idx;
    logic        cnt_wr;
    logic        base_wr;
    logic        seen_wr;
    logic        clear_wr;
    logic        out_load;
    ptc_status_t code;
  } ptc_cmd_t;

  typedef struct packed {
    ptc_status_t scalar_code;
    logic        w_bad;
    logic        s_bad;
    logic        seen_hit;
    logic        node_last;
    logic        wk_last;
    logic        clr_last;
    logic        out_free;
  } ptc_sts_t;

endpackage

// File: design/ptc_ctrl.sv
// Controller state machine of the placement table checker.
// Sequences loading, the check passes, the result and the clearing pass.
// Depends on ptc_pkg for the command and status structs.
module ptc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_stall,
  input  ptc_pkg::ptc_sts_t sts,
  output ptc_pkg::ptc_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_LOAD   = 13'b0000000000001,
    S_SCALAR = 13'b0000000000010,
    S_W_RD   = 13'b0000000000100,
    S_W_CHK  = 13'b0000000001000,
    S_W_INC  = 13'b0000000010000,
    S_B_RD   = 13'b0000000100000,
    S_B_ACC  = 13'b0000001000000,
    S_P_RD   = 13'b0000010000000,
    S_P_LEN  = 13'b0000100000000,
    S_P_CHK  = 13'b0001000000000,
    S_P_SEEN = 13'b0010000000000,
    S_OUT    = 13'b0100000000000,
    S_CLEAR  = 13'b1000000000000
  } state_t;

  state_t               state_r, state_nxt;
  ptc_pkg::ptc_status_t code_r, code_nxt;

  assign in_stall = (state_r != S_LOAD);

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    case (state_r)
      S_LOAD: begin
        cmd.accept = in_valid;
        if (in_valid && in_last) begin
          state_nxt = S_SCALAR;
        end
      end
      S_SCALAR: begin
        if (sts.scalar_code != ptc_pkg::ST_OK) begin
          code_nxt  = sts.scalar_code;
          state_nxt = S_OUT;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      S_W_RD: begin
        state_nxt = S_W_CHK;
      end
      S_W_CHK: begin
        if (sts.w_bad) begin
          code_nxt  = ptc_pkg::ST_WORKER_RANGE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_W_INC;
        end
      end
      S_W_INC: begin
        cmd.cnt_wr = 1'b1;
        if (sts.node_last) begin
          cmd.idx_clr = 1'b1;
          cmd.acc_clr = 1'b1;
          state_nxt   = S_B_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_W_RD;
        end
      end
      S_B_RD: begin
        cmd.q_by_idx = 1'b1;
        state_nxt    = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.q_by_idx = 1'b1;
        cmd.base_wr  = 1'b1;
        if (sts.wk_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_P_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_B_RD;
        end
      end
      S_P_RD: begin
        state_nxt = S_P_LEN;
      end
      S_P_LEN: begin
        state_nxt = S_P_CHK;
      end
      S_P_CHK: begin
        if (sts.s_bad) begin
          code_nxt  = ptc_pkg::ST_SLOT_RANGE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_P_SEEN;
        end
      end
      S_P_SEEN: begin
        if (sts.seen_hit) begin
          code_nxt  = ptc_pkg::ST_SLOT_REUSED;
          state_nxt = S_OUT;
        end else begin
          cmd.seen_wr = 1'b1;
          if (sts.node_last) begin
            code_nxt  = ptc_pkg::ST_OK;
            state_nxt = S_OUT;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_P_RD;
          end
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clr_last) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_LOAD;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      code_r  <= ptc_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

endmodule

// File: design/ptc_dp.sv
// Datapath of the placement table checker: configuration registers, node
// stores, queue count and base memories, the seen bitmap and the result register.
// Depends on ptc_pkg for payload, command and status types.
module ptc_dp #(
  parameter int MAX_NODES   = ptc_pkg::MAX_NODES_DEF,
  parameter int MAX_WORKERS = ptc_pkg::MAX_WORKERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  ptc_pkg::ptc_in_t                  in_data,
  input  ptc_pkg::ptc_cmd_t                 cmd,
  output ptc_pkg::ptc_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ptc_pkg::ptc_out_t                 out_data
);

  localparam int MAX_ALL = (MAX_NODES > MAX_WORKERS) ? MAX_NODES : MAX_WORKERS;
  localparam int CW      = $clog2(MAX_NODES + 1);
  localparam int IW      = $clog2(MAX_ALL + 1);
  localparam int IW1     = IW + 1;
  localparam int NAW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int WAW     = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int LW      = (CW > 15) ? CW : 15;
  localparam int LW1     = LW + 1;
  localparam int FW      = ptc_pkg::FIELD_W;

  logic [ptc_pkg::GRID_W-1:0]        worker_count_r;
  logic signed [ptc_pkg::CFG_DATA_W-1:0] seq_r;
  logic signed [ptc_pkg::CFG_DATA_W-1:0] past_r;

  logic signed [FW-1:0] wstore_mem [MAX_NODES];
  logic signed [FW-1:0] sstore_mem [MAX_NODES];
  logic [CW-1:0]        qcount_mem [MAX_WORKERS];
  logic [CW-1:0]        qbase_mem  [MAX_WORKERS];
  logic                 seen_mem   [MAX_NODES];

  logic [CW-1:0]        wcnt_r, wcnt_nxt;
  logic [CW-1:0]        scnt_r, scnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        clear_end_r, clear_end_nxt;
  logic [CW-1:0]        acc_r, acc_nxt;
  logic signed [FW-1:0] wdat_r;
  logic signed [FW-1:0] sdat_r;
  logic [CW-1:0]        qlen_r;
  logic [CW-1:0]        qbase_r;
  logic                 seen_q_r;
  logic [NAW-1:0]       seen_idx_r;
  logic                 out_valid_r, out_valid_nxt;
  ptc_pkg::ptc_out_t    out_r;

  logic                 wfull;
  logic                 sfull;
  logic [IW1-1:0]       idx_p1;
  logic [WAW-1:0]       w_addr;
  logic [WAW-1:0]       q_addr;
  logic [NAW-1:0]       seen_addr;
  logic [IW-1:0]        grid_cl;
  logic                 grid_bad;
  logic                 seq_bad;
  logic                 is_node;
  logic                 is_slot;
  ptc_pkg::ptc_status_t scalar_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= ptc_pkg::GRID_W'(1);
      seq_r          <= ptc_pkg::CFG_DATA_W'(1);
      past_r         <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ptc_pkg::REG_WORKER_COUNT:    worker_count_r <= cfg_data[ptc_pkg::GRID_W-1:0];
        ptc_pkg::REG_SEQUENCE_LENGTH: seq_r          <= cfg_data;
        ptc_pkg::REG_PAST_LENGTH:     past_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  assign wfull  = (wcnt_r == CW'(MAX_NODES));
  assign sfull  = (scnt_r == CW'(MAX_NODES));
  assign idx_p1 = IW1'(idx_r) + IW1'(1);
  assign w_addr = wdat_r[WAW-1:0];
  assign q_addr = cmd.q_by_idx ? idx_r[WAW-1:0] : w_addr;
  assign seen_addr = NAW'(LW1'(qbase_r) + LW1'(sdat_r[FW-2:0]));

  assign grid_bad = (worker_count_r == '0) || (32'(worker_count_r) > 32'(MAX_WORKERS));
  assign seq_bad  = seq_r[ptc_pkg::CFG_DATA_W-1] || (seq_r == '0) ||
                    past_r[ptc_pkg::CFG_DATA_W-1];

  always_comb begin
    if (ovf_r) begin
      scalar_code = ptc_pkg::ST_OVERFLOW;
    end else if (wcnt_r == '0) begin
      scalar_code = ptc_pkg::ST_EMPTY;
    end else if (wcnt_r != scnt_r) begin
      scalar_code = ptc_pkg::ST_MISMATCH;
    end else if (grid_bad) begin
      scalar_code = ptc_pkg::ST_BAD_GRID;
    end else if (seq_bad) begin
      scalar_code = ptc_pkg::ST_BAD_SEQ;
    end else begin
      scalar_code = ptc_pkg::ST_OK;
    end
  end

  assign sts.scalar_code = scalar_code;
  assign sts.w_bad     = wdat_r[FW-1] ||
                         ({1'b0, wdat_r[FW-2:0]} >= FW'(worker_count_r));
  assign sts.s_bad     = sdat_r[FW-1] || (LW'(sdat_r[FW-2:0]) >= LW'(qlen_r));
  assign sts.seen_hit  = seen_q_r;
  assign sts.node_last = (idx_p1 == IW1'(wcnt_r));
  assign sts.wk_last   = (32'(idx_p1) == 32'(worker_count_r));
  assign sts.clr_last  = (idx_p1 >= IW1'(clear_end_r));
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign grid_cl = (32'(worker_count_r) > 32'(MAX_WORKERS)) ? IW'(MAX_WORKERS) :
                                                              IW'(worker_count_r);

  always_comb begin
    wcnt_nxt      = wcnt_r;
    scnt_nxt      = scnt_r;
    ovf_nxt       = ovf_r;
    clear_end_nxt = clear_end_r;
    if (cmd.accept && in_data.has_worker) begin
      if (wfull) begin
        ovf_nxt = 1'b1;
      end else begin
        wcnt_nxt = wcnt_r + CW'(1);
      end
    end
    if (cmd.accept && in_data.has_slot) begin
      if (sfull) begin
        ovf_nxt = 1'b1;
      end else begin
        scnt_nxt = scnt_r + CW'(1);
      end
    end
    if (cmd.out_load) begin
      wcnt_nxt      = '0;
      scnt_nxt      = '0;
      ovf_nxt       = 1'b0;
      clear_end_nxt = (IW'(wcnt_r) > grid_cl) ? IW'(wcnt_r) : grid_cl;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = IW'(idx_p1);
    end
  end

  always_comb begin
    acc_nxt = acc_r;
    if (cmd.acc_clr) begin
      acc_nxt = '0;
    end else if (cmd.base_wr) begin
      acc_nxt = acc_r + qlen_r;
    end
  end

  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r      <= '0;
      scnt_r      <= '0;
      ovf_r       <= 1'b0;
      idx_r       <= '0;
      clear_end_r <= IW'(MAX_ALL);
      out_valid_r <= 1'b0;
    end else begin
      wcnt_r      <= wcnt_nxt;
      scnt_r      <= scnt_nxt;
      ovf_r       <= ovf_nxt;
      idx_r       <= idx_nxt;
      clear_end_r <= clear_end_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.has_worker && !wfull) begin
      wstore_mem[wcnt_r[NAW-1:0]] <= in_data.worker_id;
    end
    wdat_r <= wstore_mem[idx_r[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_data.has_slot && !sfull) begin
      sstore_mem[scnt_r[NAW-1:0]] <= in_data.slot_id;
    end
    sdat_r <= sstore_mem[idx_r[NAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      if (IW1'(idx_r) < IW1'(MAX_WORKERS)) begin
        qcount_mem[idx_r[WAW-1:0]] <= '0;
      end
    end else if (cmd.cnt_wr) begin
      qcount_mem[w_addr] <= qlen_r + CW'(1);
    end
    qlen_r <= qcount_mem[q_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.base_wr) begin
      qbase_mem[idx_r[WAW-1:0]] <= acc_r;
    end
    qbase_r <= qbase_mem[w_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_wr) begin
      if (IW1'(idx_r) < IW1'(MAX_NODES)) begin
        seen_mem[idx_r[NAW-1:0]] <= 1'b0;
      end
    end else if (cmd.seen_wr) begin
      seen_mem[seen_idx_r] <= 1'b1;
    end
    seen_q_r   <= seen_mem[seen_addr];
    seen_idx_r <= seen_addr;
  end

  assign is_node = (cmd.code == ptc_pkg::ST_WORKER_RANGE) ||
                   (cmd.code == ptc_pkg::ST_SLOT_RANGE) ||
                   (cmd.code == ptc_pkg::ST_SLOT_REUSED);
  assign is_slot = (cmd.code == ptc_pkg::ST_SLOT_RANGE) ||
                   (cmd.code == ptc_pkg::ST_SLOT_REUSED);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status         <= cmd.code;
      out_r.node_index     <= is_node ? ptc_pkg::COUNT_W'(idx_r) : '0;
      out_r.bad_worker     <= is_node ? wdat_r : '0;
      out_r.bad_slot       <= is_slot ? sdat_r : '0;
      out_r.queue_length   <= is_slot ? ptc_pkg::COUNT_W'(qlen_r) : '0;
      out_r.worker_entries <= ptc_pkg::COUNT_W'(wcnt_r);
      out_r.slot_entries   <= ptc_pkg::COUNT_W'(scnt_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: design/placement_table_checker.sv
// Placement table checker: one input transaction is loaded per cycle while input is not stalled; the one marked
// last starts the checks: the scalar checks, then a worker range and count pass per node, a base pass
// per worker and a slot range and seen-bitmap pass per node, stopping at the first error, then the result.
// After each result a clearing pass over max(node count, clamped worker count) entries, at
// least one, runs with input stalled; after reset it covers max(MAX_NODES, MAX_WORKERS) entries.
// Reset is synchronous, active low; state and count registers return to their reset values, memories are not reset.
module placement_table_checker #(
  parameter int MAX_NODES   = ptc_pkg::MAX_NODES_DEF,
  parameter int MAX_WORKERS = ptc_pkg::MAX_WORKERS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ptc_pkg::ptc_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ptc_pkg::ptc_out_t              out_data
);

  ptc_pkg::ptc_cmd_t cmd;
  ptc_pkg::ptc_sts_t sts;

  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ptc_dp #(
    .MAX_NODES   (MAX_NODES),
    .MAX_WORKERS (MAX_WORKERS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last) |=> in_stall)
    else $error("Input was not stalled after the last transaction of a table.");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("Result register loaded while a transaction was still pending.");

  a_clear_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> (in_stall && out_valid))
    else $error("Clearing pass did not follow the result.");

  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.cnt_wr, cmd.base_wr, cmd.seen_wr, cmd.clear_wr}))
    else $error("More than one memory write command in one cycle.");
`endif

endmodule

// File: tb/tb_placement_table_checker.sv
// Self-checking testbench for placement_table_checker: a scoreboard class predicts
// the verdict of each placement table, while plain tasks drive tables and configuration.
// Depends on ptc_pkg for the payload structs, status codes and register indexes.
`timescale 1ns / 1ps

import ptc_pkg::*;

class ptc_scoreboard;
  logic [GRID_W-1:0]         grid;
  logic [CFG_DATA_W-1:0]     seq_len;
  logic [CFG_DATA_W-1:0]     past_len;
  logic signed [FIELD_W-1:0] wk_mem [MAX_NODES_DEF];
  logic signed [FIELD_W-1:0] sl_mem [MAX_NODES_DEF];
  int                        wk_cnt;
  int                        sl_cnt;
  bit                        ovf;
  ptc_out_t                  verdict_q [$];
  int                        errors;

  function new();
    grid     = 1;
    seq_len  = 1;
    past_len = 0;
    wk_cnt   = 0;
    sl_cnt   = 0;
    ovf      = 0;
    errors   = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      REG_WORKER_COUNT:    grid = v[GRID_W-1:0];
      REG_SEQUENCE_LENGTH: seq_len = v;
      REG_PAST_LENGTH:     past_len = v;
      default: ;
    endcase
  endfunction

  function int pending();
    return verdict_q.size();
  endfunction

  function void note_item(ptc_in_t d);
    ptc_out_t e;
    int       qc [MAX_WORKERS_DEF];
    int       base [MAX_WORKERS_DEF];
    bit       seen [MAX_NODES_DEF];
    int       g;
    int       wv;
    int       sv;
    int       acc;
    bit       hit;
    if (d.has_worker) begin
      if (wk_cnt < MAX_NODES_DEF) begin
        wk_mem[wk_cnt] = d.worker_id;
        wk_cnt++;
      end else begin
        ovf = 1;
      end
    end
    if (d.has_slot) begin
      if (sl_cnt < MAX_NODES_DEF) begin
        sl_mem[sl_cnt] = d.slot_id;
        sl_cnt++;
      end else begin
        ovf = 1;
      end
    end
    if (!d.last) return;
    e = '0;
    e.status = ST_OK;
    g = grid;
    hit = 0;
    foreach (qc[i]) qc[i] = 0;
    foreach (seen[i]) seen[i] = 0;
    if (ovf) begin
      e.status = ST_OVERFLOW;
    end else if (wk_cnt == 0) begin
      e.status = ST_EMPTY;
    end else if (wk_cnt != sl_cnt) begin
      e.status = ST_MISMATCH;
    end else if (g == 0 || g > MAX_WORKERS_DEF) begin
      e.status = ST_BAD_GRID;
    end else if (seq_len[31] || seq_len == 0 || past_len[31]) begin
      e.status = ST_BAD_SEQ;
    end else begin
      for (int i = 0; i < wk_cnt; i++) begin
        wv = wk_mem[i];
        if (wv < 0 || wv >= g) begin
          e.status = ST_WORKER_RANGE;
          e.node_index = COUNT_W'(i);
          e.bad_worker = wk_mem[i];
          hit = 1;
          break;
        end
        qc[wv]++;
      end
      if (!hit) begin
        acc = 0;
        for (int i = 0; i < g; i++) begin
          base[i] = acc;
          acc += qc[i];
        end
        for (int i = 0; i < wk_cnt; i++) begin
          wv = wk_mem[i];
          sv = sl_mem[i];
          if (sv < 0 || sv >= qc[wv]) begin
            e.status = ST_SLOT_RANGE;
            hit = 1;
          end else if (seen[base[wv] + sv]) begin
            e.status = ST_SLOT_REUSED;
            hit = 1;
          end
          if (hit) begin
            e.node_index = COUNT_W'(i);
            e.bad_worker = wk_mem[i];
            e.bad_slot = sl_mem[i];
            e.queue_length = COUNT_W'(qc[wv]);
            break;
          end
          seen[base[wv] + sv] = 1;
        end
      end
    end
    e.worker_entries = COUNT_W'(wk_cnt);
    e.slot_entries = COUNT_W'(sl_cnt);
    verdict_q.push_back(e);
    wk_cnt = 0;
    sl_cnt = 0;
    ovf = 0;
  endfunction

  function void cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  function void check_result(ptc_out_t got);
    ptc_out_t e;
    if (verdict_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual status %0d", $time,
               int'(got.status));
      return;
    end
    e = verdict_q.pop_front();
    cmp_field("status", int'(e.status), int'(got.status));
    cmp_field("node_index", int'(e.node_index), int'(got.node_index));
    cmp_field("bad_worker", int'(e.bad_worker), int'(got.bad_worker));
    cmp_field("bad_slot", int'(e.bad_slot), int'(got.bad_slot));
    cmp_field("queue_length", int'(e.queue_length), int'(got.queue_length));
    cmp_field("worker_entries", int'(e.worker_entries), int'(got.worker_entries));
    cmp_field("slot_entries", int'(e.slot_entries), int'(got.slot_entries));
  endfunction
endclass

module tb_placement_table_checker;
  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int SETTLE       = 1100;
  localparam int HOLD_CYCLES  = 600;
  localparam int LIMIT        = 2000000;
  localparam int TARGET_ITEMS = 1700;

  typedef enum int {F_NONE, F_WORKER, F_SLOT, F_REUSE, F_COUNT} fault_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  ptc_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b1;
  ptc_out_t              out_data;

  ptc_scoreboard sb;
  ptc_in_t       table_q [$];
  int unsigned   cycles = 0;
  int            random_items = 0;
  bit            no_idle = 0;
  bit            hold_req = 0;

  always #CLK_HALF clk = ~clk;

  placement_table_checker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_item(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  function automatic ptc_in_t mk(bit hw, int w, bit hs, int s, bit l);
    ptc_in_t d;
    d.has_worker = hw;
    d.worker_id = w[FIELD_W-1:0];
    d.has_slot = hs;
    d.slot_id = s[FIELD_W-1:0];
    d.last = l;
    return d;
  endfunction

  task automatic send_item(input ptc_in_t d);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_table();
    ptc_in_t d;
    for (int i = 0; i < table_q.size(); i++) begin
      if (i < table_q.size() - 1 && $urandom_range(0, 9) == 0)
        send_item(mk(0, $urandom, 0, $urandom, 0));
      d = table_q[i];
      d.last = (i == table_q.size() - 1);
      send_item(d);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_cfg(input logic [GRID_W-1:0] g, input logic [CFG_DATA_W-1:0] sq,
                           input logic [CFG_DATA_W-1:0] pl);
    logic [CFG_DATA_W-1:0] gdata;
    gdata = $urandom;
    gdata[GRID_W-1:0] = g;
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WORKER_COUNT;
    cfg_data <= gdata;
    sb.write_reg(REG_WORKER_COUNT, gdata);
    @(posedge clk);
    cfg_index <= REG_SEQUENCE_LENGTH;
    cfg_data <= sq;
    sb.write_reg(REG_SEQUENCE_LENGTH, sq);
    @(posedge clk);
    cfg_index <= REG_PAST_LENGTH;
    cfg_data <= pl;
    sb.write_reg(REG_PAST_LENGTH, pl);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic make_table(input int n, input int g, input fault_t f);
    int wk [MAX_NODES_DEF];
    int sl [MAX_NODES_DEF];
    int cnt [MAX_WORKERS_DEF];
    int wmax;
    int i;
    int j;
    int k;
    int tmp;
    foreach (cnt[x]) cnt[x] = 0;
    wmax = $urandom_range(0, 1) ? g - 1 : ((g - 1 < 3) ? g - 1 : 3);
    for (i = 0; i < n; i++) begin
      wk[i] = $urandom_range(0, wmax);
      sl[i] = cnt[wk[i]];
      cnt[wk[i]]++;
    end
    repeat (n) begin
      i = $urandom_range(0, n - 1);
      j = $urandom_range(0, n - 1);
      if (wk[i] == wk[j]) begin
        tmp = sl[i];
        sl[i] = sl[j];
        sl[j] = tmp;
      end
    end
    k = $urandom_range(0, n - 1);
    case (f)
      F_WORKER: wk[k] = $urandom_range(0, 1) ? -int'($urandom_range(1, 32768))
                                             : int'($urandom_range(g, 32767));
      F_SLOT:   sl[k] = $urandom_range(0, 1) ? -int'($urandom_range(1, 32768))
                                             : int'($urandom_range(cnt[wk[k]], 32767));
      F_REUSE: begin
        for (j = 0; j < n; j++) begin
          if (j != k && wk[j] == wk[k]) begin
            sl[k] = sl[j];
            break;
          end
        end
      end
      default: ;
    endcase
    table_q.delete();
    for (i = 0; i < n; i++) table_q.push_back(mk(1, wk[i], 1, sl[i], 0));
    if (f == F_COUNT) begin
      case ($urandom_range(0, 2))
        0: table_q[k].has_slot = 1'b0;
        1: table_q[k].has_worker = 1'b0;
        default: table_q.push_back(mk(0, $urandom, 1, $urandom_range(0, 3), 0));
      endcase
    end
  endtask

  initial begin : receiver
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid && !hold_req);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
    end
  end

  initial begin : stimulus
    logic [GRID_W-1:0]     grid_v;
    logic [CFG_DATA_W-1:0] seq_v;
    logic [CFG_DATA_W-1:0] past_v;
    int                    g;
    int                    n;
    int                    kind;
    int                    phase;
    fault_t                f;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    send_item(mk(0, 0, 0, 0, 1));
    send_item(mk(0, 0, 1, 5, 1));
    send_item(mk(1, 0, 1, 0, 1));
    send_item(mk(1, 0, 0, 0, 0));
    send_item(mk(1, 0, 0, 0, 1));
    apply_cfg(256, 32'h7fff_ffff, 32'h7fff_ffff);
    send_item(mk(1, 255, 1, 0, 1));
    send_item(mk(1, 32767, 1, 32767, 1));
    send_item(mk(1, -32768, 1, -32768, 1));
    send_item(mk(1, 3, 1, 1, 0));
    send_item(mk(1, 3, 1, 0, 0));
    send_item(mk(1, 3, 1, 1, 1));
    send_item(mk(1, 0, 1, -1, 1));
    send_item(mk(1, 1, 1, 0, 0));
    send_item(mk(1, 1, 1, 2, 1));
    apply_cfg(0, 1, 0);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(257, 1, 0);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(511, 32'h8000_0000, 32'h8000_0000);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(1, 32'h8000_0000, 0);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(1, 0, 0);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(1, 1, 32'h8000_0000);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(1, 1, 32'hffff_ffff);
    send_item(mk(1, 0, 1, 0, 1));
    apply_cfg(256, 1, 0);
    send_item(mk(1, 0, 0, 0, 1));

    phase = 0;
    while (random_items < TARGET_ITEMS || phase < 5) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: grid_v = 256;
        1: grid_v = $urandom_range(9, 255);
        default: grid_v = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 3))
        0: seq_v = 1;
        1: seq_v = 32'h7fff_ffff;
        2: seq_v = $urandom_range(1, 1000);
        default: seq_v = ($urandom & 32'h7fff_ffff) | 32'h1;
      endcase
      case ($urandom_range(0, 3))
        0: past_v = 0;
        1: past_v = 32'h7fff_ffff;
        2: past_v = $urandom_range(0, 1000);
        default: past_v = $urandom & 32'h7fff_ffff;
      endcase
      if ($urandom_range(0, 9) >= 8) begin
        case ($urandom_range(0, 3))
          0: grid_v = 0;
          1: grid_v = $urandom_range(257, 511);
          2: seq_v = $urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000);
          default: past_v = $urandom | 32'h8000_0000;
        endcase
      end
      apply_cfg(grid_v, seq_v, past_v);
      g = (grid_v >= 1 && grid_v <= MAX_WORKERS_DEF) ? int'(grid_v) : $urandom_range(1, 8);

      if (phase == 2) begin
        table_q.delete();
        for (int i = 0; i < MAX_NODES_DEF - 1; i++)
          table_q.push_back(mk(1, $urandom_range(0, 3), 1, $urandom_range(0, 3), 0));
        table_q.push_back(mk(1, 0, 0, 0, 0));
        table_q.push_back(mk(1, 0, 1, 0, 0));
        send_table();
        random_items += table_q.size();
      end

      if (phase == 4) begin
        hold_req = 1;
        repeat (6) begin
          make_table($urandom_range(1, 4), g, F_NONE);
          send_table();
          random_items += table_q.size();
        end
        in_valid <= 1'b0;
        wait_drained();
      end

      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 99);
        if (kind < 60) begin
          n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 12);
          f = $urandom_range(0, 1) ? F_NONE : fault_t'($urandom_range(1, 4));
          make_table(n, g, f);
        end else if (kind < 85) begin
          table_q.delete();
          repeat ($urandom_range(1, 8))
            table_q.push_back(mk($urandom_range(0, 1),
                                 $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 3),
                                 $urandom_range(0, 1),
                                 $urandom_range(0, 1) ? int'($urandom) : $urandom_range(0, 3),
                                 0));
        end else begin
          table_q.delete();
          repeat ($urandom_range(1, 4))
            table_q.push_back(mk(0, $urandom, $urandom_range(0, 1), $urandom, 0));
        end
        send_table();
        random_items += table_q.size();
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

// File: files.f
design/ptc_pkg.sv
design/ptc_ctrl.sv
design/ptc_dp.sv
design/placement_table_checker.sv
tb/tb_placement_table_checker.sv
